// ===== sv/arpc_pkg.sv =====
package arpc_pkg;

    typedef enum logic [1:0]
    {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_PACKET = 2'd3
    } mode_t;

    typedef enum logic [2:0]
    {
        ST_DONE   = 3'd0,
        ST_HIT    = 3'd1,
        ST_MISS   = 3'd2,
        ST_REPLY  = 3'd3,
        ST_REJECT = 3'd4
    } status_t;

    localparam logic [10:0] MIN_PKT_LEN    = 11'd28;
    localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  HLEN_ETHERNET  = 8'd6;
    localparam logic [7:0]  PLEN_IPV4      = 8'd4;
    localparam logic [15:0] OP_REQUEST     = 16'h0001;
    localparam logic [31:0] AGE_LIMIT_RST  = 32'd3000;
    localparam logic        CFG_LOCAL_IP   = 1'b0;
    localparam logic        CFG_AGE_LIMIT  = 1'b1;

    // classified command handed from front to back
    typedef struct packed
    {
        logic        do_lookup;
        logic        do_learn;
        logic        do_tick;
        logic        reject;
        logic        reply;
        logic [31:0] now_ticks;
        logic [31:0] ip_address;
        logic [47:0] mac_address;
    } cmd_t;

endpackage

// ===== sv/arpc_front.sv =====
module arpc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic [31:0]         now_ticks,
    input  logic [31:0]         ip_address,
    input  logic [47:0]         mac_address,
    input  logic [31:0]         query_ip,
    input  logic [10:0]         packet_length,
    input  logic [15:0]         hw_type,
    input  logic [15:0]         proto_type,
    input  logic [7:0]          hw_addr_len,
    input  logic [7:0]          proto_addr_len,
    input  logic [15:0]         opcode,
    input  logic [31:0]         host_ip,
    output logic                q_valid,
    input  logic                q_ready,
    output arpc_pkg::cmd_t      q_cmd
);

    // two-entry queue
    arpc_pkg::cmd_t mem_reg [2];
    logic           wptr_reg, rptr_reg;
    logic [1:0]     cnt_reg;
    arpc_pkg::cmd_t cmd;
    logic           bad;
    logic           push, pop;

    always_comb
    begin
        bad = (packet_length < arpc_pkg::MIN_PKT_LEN) || (hw_type != arpc_pkg::HTYPE_ETHERNET)
            || (proto_type != arpc_pkg::PTYPE_IPV4) || (hw_addr_len != arpc_pkg::HLEN_ETHERNET)
            || (proto_addr_len != arpc_pkg::PLEN_IPV4);
        cmd = '0;
        cmd.now_ticks   = now_ticks;
        cmd.ip_address  = ip_address;
        cmd.mac_address = mac_address;
        case (mode)
            arpc_pkg::MODE_LOOKUP: cmd.do_lookup = 1'b1;
            arpc_pkg::MODE_INSERT: cmd.do_learn  = 1'b1;
            arpc_pkg::MODE_TICK:   cmd.do_tick   = 1'b1;
            default:
            begin
                cmd.reject   = bad;
                cmd.do_learn = !bad;
                cmd.reply    = !bad && (opcode == arpc_pkg::OP_REQUEST)
                               && (query_ip == host_ip);
            end
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/arpc_back.sv =====
module arpc_back
#(
    parameter int ENTRIES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  arpc_pkg::cmd_t      q_cmd,
    input  logic [31:0]         age_limit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          status,
    output logic [47:0]         result_mac,
    output logic [31:0]         result_ip
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_OUT
    } state_t;

    state_t         state_reg;
    arpc_pkg::cmd_t cmd_reg;
    logic [IW-1:0]  idx_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]    ip_reg   [ENTRIES];
    logic [47:0]    mac_reg  [ENTRIES];
    logic [31:0]    time_reg [ENTRIES];
    logic           match_reg, free_reg;
    logic [IW-1:0]  match_idx_reg, free_idx_reg, old_idx_reg;
    logic [31:0]    old_time_reg;
    logic [47:0]    hit_mac_reg;
    logic [2:0]     status_reg;
    logic [47:0]    rmac_reg;
    logic [31:0]    rip_reg;
    logic [IW-1:0]  tgt;
    logic           last;

    assign q_ready    = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign status     = status_reg;
    assign result_mac = rmac_reg;
    assign result_ip  = rip_reg;
    assign last       = (32'(idx_reg) == ENTRIES - 1);
    assign tgt        = match_reg ? match_idx_reg : (free_reg ? free_idx_reg : old_idx_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE && cmd_reg.do_learn)
        begin
            ip_reg[tgt]   <= cmd_reg.ip_address;
            mac_reg[tgt]  <= cmd_reg.mac_address;
            time_reg[tgt] <= cmd_reg.now_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            match_idx_reg <= '0;
            free_idx_reg  <= '0;
            old_idx_reg   <= '0;
            old_time_reg  <= '0;
            hit_mac_reg   <= '0;
            status_reg    <= '0;
            rmac_reg      <= '0;
            rip_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        idx_reg   <= '0;
                        match_reg <= 1'b0;
                        free_reg  <= 1'b0;
                        state_reg <= (q_cmd.reject) ? S_WRITE : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // one entry per cycle: match, first free, oldest, aging
                    if (!match_reg && valid_reg[idx_reg] && ip_reg[idx_reg] == cmd_reg.ip_address)
                    begin
                        match_reg     <= 1'b1;
                        match_idx_reg <= idx_reg;
                        hit_mac_reg   <= mac_reg[idx_reg];
                    end
                    if (!free_reg && !valid_reg[idx_reg])
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    if (idx_reg == '0 || time_reg[idx_reg] < old_time_reg)
                    begin
                        old_idx_reg  <= idx_reg;
                        old_time_reg <= time_reg[idx_reg];
                    end
                    if (cmd_reg.do_tick && valid_reg[idx_reg]
                        && (cmd_reg.now_ticks - time_reg[idx_reg]) > age_limit)
                    begin
                        valid_reg[idx_reg] <= 1'b0;
                    end
                    if (last)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_WRITE:
                begin
                    if (cmd_reg.do_learn)
                    begin
                        valid_reg[tgt] <= 1'b1;
                    end
                    rmac_reg <= '0;
                    rip_reg  <= '0;
                    if (cmd_reg.reject)
                    begin
                        status_reg <= arpc_pkg::ST_REJECT;
                    end
                    else if (cmd_reg.do_lookup)
                    begin
                        status_reg <= match_reg ? arpc_pkg::ST_HIT : arpc_pkg::ST_MISS;
                        rmac_reg   <= match_reg ? hit_mac_reg : 48'd0;
                    end
                    else if (cmd_reg.reply)
                    begin
                        status_reg <= arpc_pkg::ST_REPLY;
                        rmac_reg   <= cmd_reg.mac_address;
                        rip_reg    <= cmd_reg.ip_address;
                    end
                    else
                    begin
                        status_reg <= arpc_pkg::ST_DONE;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/arp_neighbor_cache.sv =====
// An input word passes the back end's idle, scan and write states before its
// result word is shown; the table scan in the back end checks one entry per cycle,
// and rejected packets skip the scan. The back end takes no new word until the
// result word has been taken.
// A two-word queue lets input words be taken while the back end works.
// Reset (rst_n, async, active low) clears all valid bits, host_ip to 0,
// age_limit to 3000.
module arp_neighbor_cache
#(
    parameter int ENTRIES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[1:0], now_ticks[33:2], ip_address[65:34], mac_address[113:66],
    // query_ip[145:114], packet_length[156:146], hw_type[172:157],
    // proto_type[188:173], hw_addr_len[196:189], proto_addr_len[204:197],
    // opcode[220:205], zero fill
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], result_mac[50:3], result_ip[82:51], zero fill
    output logic [87:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [31:0]    host_ip_reg, age_limit_reg;
    logic           q_valid, q_ready;
    arpc_pkg::cmd_t q_cmd;
    logic [2:0]     status;
    logic [47:0]    result_mac;
    logic [31:0]    result_ip;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {5'd0, result_ip, result_mac, status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_ip_reg   <= '0;
            age_limit_reg <= arpc_pkg::AGE_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == arpc_pkg::CFG_LOCAL_IP)
            begin
                host_ip_reg <= cfg_data;
            end
            else
            begin
                age_limit_reg <= cfg_data;
            end
        end
    end

    arpc_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .mode           (s_tdata[1:0]),
        .now_ticks      (s_tdata[33:2]),
        .ip_address     (s_tdata[65:34]),
        .mac_address    (s_tdata[113:66]),
        .query_ip       (s_tdata[145:114]),
        .packet_length  (s_tdata[156:146]),
        .hw_type        (s_tdata[172:157]),
        .proto_type     (s_tdata[188:173]),
        .hw_addr_len    (s_tdata[196:189]),
        .proto_addr_len (s_tdata[204:197]),
        .opcode         (s_tdata[220:205]),
        .host_ip        (host_ip_reg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_cmd          (q_cmd)
    );

    arpc_back #(.ENTRIES(ENTRIES)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (q_cmd),
        .age_limit  (age_limit_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .status     (status),
        .result_mac (result_mac),
        .result_ip  (result_ip)
    );

endmodule

// ===== sv/arpc_checker.sv =====
module arpc_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [87:0]  m_tdata
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= arpc_pkg::ST_REJECT)
        else $error("bad status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != arpc_pkg::ST_REPLY |-> m_tdata[82:51] == 32'd0)
        else $error("result ip set without reply");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == arpc_pkg::ST_DONE || m_tdata[2:0] == arpc_pkg::ST_MISS
                     || m_tdata[2:0] == arpc_pkg::ST_REJECT)
        |-> m_tdata[50:3] == 48'd0)
        else $error("result mac set without hit or reply");

endmodule

bind arp_neighbor_cache arpc_checker u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
